// ----- rtl/qkve_pkg.sv -----
`timescale 1ns / 1ps

package qkve_pkg;

    // value buffer and key sizes
    localparam int VALUE_MAX = 64;
    localparam int KEY_MAX   = 28;
    localparam int CNT_W     = $clog2(VALUE_MAX + 1);
    localparam int ADDR_W    = $clog2(VALUE_MAX);
    localparam int KEY_IDX_W = $clog2(KEY_MAX);
    localparam int KEY_LEN_W = 5;
    localparam int KEY_REGS  = 7;
    localparam int KEY_W     = KEY_REGS * 32;

    // register port
    localparam int PADDR_W   = 5;
    localparam int PDATA_W   = 32;
    localparam int REG_IDX_W = PADDR_W - 2;

    // command queue between scanner and drain
    localparam int CMD_DEPTH = 2;
    localparam int CMD_PTR_W = $clog2(CMD_DEPTH);
    localparam int CMD_CNT_W = $clog2(CMD_DEPTH + 1);

    // characters of interest
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_COLON  = 8'h3A;
    localparam logic [7:0] CH_LPAR   = 8'h28;
    localparam logic [7:0] CH_RPAR   = 8'h29;
    localparam logic [7:0] CH_LBRACE = 8'h7B;
    localparam logic [7:0] CH_RBRACE = 8'h7D;
    localparam logic [7:0] CH_NUL    = 8'h00;

    // reset key: translatedText
    localparam logic [KEY_LEN_W-1:0] KEY_LEN_RESET = 5'd14;
    localparam logic [KEY_W-1:0] KEY_CHARS_RESET = {
        32'd0, 32'd0, 32'd0, 32'd29816,
        32'd1700029541, 32'd1952541811, 32'd1851880052
    };

    typedef struct packed {
        logic       kind;
        logic [7:0] data_byte;
    } scan_item_t;

    typedef struct packed {
        logic [7:0] value_byte;
        logic       last;
        logic       empty_res;
        logic       truncated;
    } value_item_t;

    // one finished value waiting to be drained
    typedef struct packed {
        logic [CNT_W-1:0] cnt;
        logic             overflow;
    } cmd_t;

    // buffer write from scanner
    typedef struct packed {
        logic              en;
        logic [ADDR_W-1:0] addr;
        logic [7:0]        data;
    } buf_wr_t;

endpackage

// ----- rtl/qkve_regs.sv -----
`timescale 1ns / 1ps

module qkve_regs
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [qkve_pkg::PADDR_W-1:0]        paddr,
    input  logic [qkve_pkg::PDATA_W-1:0]        pwdata,
    output logic [qkve_pkg::PDATA_W-1:0]        prdata,
    output logic                                pready,
    output logic [qkve_pkg::KEY_LEN_W-1:0]      key_length,
    output logic [qkve_pkg::KEY_W-1:0]          key_chars
);

    localparam logic [qkve_pkg::REG_IDX_W-1:0] REG_KEY_LENGTH      = 3'd0;
    localparam logic [qkve_pkg::REG_IDX_W-1:0] REG_KEY_CHARS_FIRST = 3'd1;

    logic [qkve_pkg::KEY_LEN_W-1:0] key_length_reg;
    logic [qkve_pkg::KEY_W-1:0]     key_chars_reg;
    logic [qkve_pkg::REG_IDX_W-1:0] reg_idx;
    logic                           wr_en;

    assign reg_idx = paddr[qkve_pkg::PADDR_W-1:2];
    assign wr_en   = psel && penable && pwrite;
    assign pready  = 1'b1;

    // register writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_length_reg <= qkve_pkg::KEY_LEN_RESET;
            key_chars_reg  <= qkve_pkg::KEY_CHARS_RESET;
        end
        else if (wr_en)
        begin
            if (reg_idx == REG_KEY_LENGTH)
            begin
                key_length_reg <= pwdata[qkve_pkg::KEY_LEN_W-1:0];
            end
            for (int i = 0; i < qkve_pkg::KEY_REGS; i++)
            begin
                if (reg_idx == qkve_pkg::REG_IDX_W'(REG_KEY_CHARS_FIRST + i))
                begin
                    key_chars_reg[32*i +: 32] <= pwdata;
                end
            end
        end
    end

    // register readback
    always_comb
    begin
        prdata = '0;
        if (reg_idx == REG_KEY_LENGTH)
        begin
            prdata = qkve_pkg::PDATA_W'(key_length_reg);
        end
        for (int i = 0; i < qkve_pkg::KEY_REGS; i++)
        begin
            if (reg_idx == qkve_pkg::REG_IDX_W'(REG_KEY_CHARS_FIRST + i))
            begin
                prdata = key_chars_reg[32*i +: 32];
            end
        end
    end

    assign key_length = key_length_reg;
    assign key_chars  = key_chars_reg;

endmodule

// ----- rtl/qkve_front.sv -----
`timescale 1ns / 1ps

module qkve_front
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            scan_valid,
    output logic                            scan_stall,
    input  qkve_pkg::scan_item_t            scan_data,
    input  logic [qkve_pkg::KEY_LEN_W-1:0]  key_length,
    input  logic [qkve_pkg::KEY_W-1:0]      key_chars,
    input  logic                            cmd_full,
    input  logic                            back_busy,
    output logic                            cmd_push,
    output qkve_pkg::cmd_t                  cmd_data,
    output qkve_pkg::buf_wr_t               buf_wr
);

    logic                         inq_reg, inq_next;
    logic                         colon_reg, colon_next;
    logic                         found_reg, found_next;
    logic                         fin_reg, fin_next;
    logic                         ebz_reg, ebz_next;
    logic                         match_reg, match_next;
    logic                         ovf_reg, ovf_next;
    logic [qkve_pkg::CNT_W-1:0]   cnt_reg, cnt_next;
    logic [qkve_pkg::CNT_W-1:0]   key_len_ext;
    logic [qkve_pkg::KEY_IDX_W-1:0] key_idx;
    logic [7:0]                   key_byte;
    logic [7:0]                   c;
    logic                         mismatch;
    logic                         accept;

    function automatic logic [7:0] fold_case(input logic [7:0] ch);
        return (ch >= 8'h41 && ch <= 8'h5A) ? ch + 8'h20 : ch;
    endfunction

    // hold input while a new value could overwrite the buffer being drained
    assign scan_stall = cmd_full || (found_reg && !fin_reg && back_busy);
    assign accept     = scan_valid && !scan_stall;
    assign c          = scan_data.data_byte;

    // key character at the current position
    assign key_len_ext = qkve_pkg::CNT_W'(key_length);
    assign key_idx     = (cnt_reg < qkve_pkg::KEY_MAX) ? cnt_reg[qkve_pkg::KEY_IDX_W-1:0] : '0;
    assign key_byte    = key_chars[8*key_idx +: 8];
    assign mismatch    = (cnt_reg >= key_len_ext) || (cnt_reg >= qkve_pkg::KEY_MAX)
                         || (fold_case(c) != fold_case(key_byte));

    // scan state update
    always_comb
    begin
        inq_next      = inq_reg;
        colon_next    = colon_reg;
        found_next    = found_reg;
        fin_next      = fin_reg;
        ebz_next      = ebz_reg;
        match_next    = match_reg;
        ovf_next      = ovf_reg;
        cnt_next      = cnt_reg;
        cmd_push      = 1'b0;
        cmd_data.cnt      = cnt_reg;
        cmd_data.overflow = ovf_reg;
        buf_wr.en     = 1'b0;
        buf_wr.addr   = cnt_reg[qkve_pkg::ADDR_W-1:0];
        buf_wr.data   = c;
        if (accept)
        begin
            if (scan_data.kind)
            begin
                // end of message
                inq_next   = 1'b0;
                colon_next = 1'b0;
                found_next = 1'b0;
                fin_next   = 1'b0;
                ebz_next   = 1'b0;
                match_next = 1'b1;
                ovf_next   = 1'b0;
                cnt_next   = '0;
            end
            else if (!fin_reg)
            begin
                if (c == qkve_pkg::CH_QUOTE)
                begin
                    if (!inq_reg)
                    begin
                        inq_next = 1'b1;
                    end
                    else
                    begin
                        inq_next = 1'b0;
                        if (found_reg)
                        begin
                            fin_next = 1'b1;
                            cmd_push = 1'b1;
                        end
                        else if (match_reg && key_length <= qkve_pkg::KEY_MAX
                                 && cnt_reg == key_len_ext && !colon_reg)
                        begin
                            found_next = 1'b1;
                        end
                        cnt_next   = '0;
                        match_next = 1'b1;
                        ebz_next   = 1'b0;
                        ovf_next   = 1'b0;
                    end
                end
                else if (inq_reg)
                begin
                    if (!ebz_reg)
                    begin
                        if (c == qkve_pkg::CH_NUL)
                        begin
                            ebz_next = 1'b1;
                        end
                        else if (found_reg)
                        begin
                            // value character into the buffer
                            if (cnt_reg < qkve_pkg::VALUE_MAX)
                            begin
                                buf_wr.en = 1'b1;
                                cnt_next  = cnt_reg + qkve_pkg::CNT_W'(1);
                            end
                            else
                            begin
                                ovf_next = 1'b1;
                            end
                        end
                        else
                        begin
                            // key compare
                            if (mismatch)
                            begin
                                match_next = 1'b0;
                            end
                            if (cnt_reg < qkve_pkg::VALUE_MAX)
                            begin
                                cnt_next = cnt_reg + qkve_pkg::CNT_W'(1);
                            end
                        end
                    end
                end
                else
                begin
                    if (c inside {qkve_pkg::CH_LPAR, qkve_pkg::CH_RPAR,
                                  qkve_pkg::CH_LBRACE, qkve_pkg::CH_RBRACE})
                    begin
                        colon_next = 1'b0;
                    end
                    else if (c == qkve_pkg::CH_COLON)
                    begin
                        colon_next = 1'b1;
                    end
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            inq_reg   <= 1'b0;
            colon_reg <= 1'b0;
            found_reg <= 1'b0;
            fin_reg   <= 1'b0;
            ebz_reg   <= 1'b0;
            match_reg <= 1'b1;
            ovf_reg   <= 1'b0;
            cnt_reg   <= '0;
        end
        else
        begin
            inq_reg   <= inq_next;
            colon_reg <= colon_next;
            found_reg <= found_next;
            fin_reg   <= fin_next;
            ebz_reg   <= ebz_next;
            match_reg <= match_next;
            ovf_reg   <= ovf_next;
            cnt_reg   <= cnt_next;
        end
    end

endmodule

// ----- rtl/qkve_cmd_fifo.sv -----
`timescale 1ns / 1ps

module qkve_cmd_fifo
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  qkve_pkg::cmd_t  push_data,
    output logic            full,
    input  logic            pop,
    output qkve_pkg::cmd_t  pop_data,
    output logic            avail
);

    qkve_pkg::cmd_t                  entry_reg [qkve_pkg::CMD_DEPTH];
    logic [qkve_pkg::CMD_PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [qkve_pkg::CMD_PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [qkve_pkg::CMD_CNT_W-1:0]  count_reg, count_next;
    logic                            do_push;
    logic                            do_pop;

    localparam logic [qkve_pkg::CMD_PTR_W-1:0] PTR_LAST =
        qkve_pkg::CMD_PTR_W'(qkve_pkg::CMD_DEPTH - 1);

    assign full     = (count_reg == qkve_pkg::CMD_CNT_W'(qkve_pkg::CMD_DEPTH));
    assign avail    = (count_reg != '0);
    assign do_push  = push && !full;
    assign do_pop   = pop && avail;
    assign pop_data = entry_reg[rd_ptr_reg];

    // pointer and fill count
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0
                          : wr_ptr_reg + qkve_pkg::CMD_PTR_W'(1);
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0
                          : rd_ptr_reg + qkve_pkg::CMD_PTR_W'(1);
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + qkve_pkg::CMD_CNT_W'(1);
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - qkve_pkg::CMD_CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // queue storage
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

// ----- rtl/qkve_back.sv -----
`timescale 1ns / 1ps

module qkve_back
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    cmd_avail,
    input  qkve_pkg::cmd_t          cmd_data,
    output logic                    cmd_pop,
    input  qkve_pkg::buf_wr_t       buf_wr,
    output logic                    busy,
    output logic                    value_valid,
    input  logic                    value_stall,
    output qkve_pkg::value_item_t   value_data
);

    typedef enum logic [1:0] {
        B_IDLE,
        B_READ,
        B_SEND
    } back_state_t;

    back_state_t                    state_reg;
    logic [qkve_pkg::ADDR_W-1:0]    idx_reg;
    logic [qkve_pkg::CNT_W-1:0]     cnt_reg;
    logic                           ovf_reg;
    logic [7:0]                     rd_data_reg;
    logic [7:0]                     value_buf [qkve_pkg::VALUE_MAX];
    logic                           is_empty;
    logic                           is_last;

    assign cmd_pop     = (state_reg == B_IDLE) && cmd_avail;
    assign busy        = cmd_avail || (state_reg != B_IDLE);
    assign is_empty    = (cnt_reg == '0);
    assign is_last     = is_empty
                         || (qkve_pkg::CNT_W'(idx_reg) + qkve_pkg::CNT_W'(1) == cnt_reg);
    assign value_valid = (state_reg == B_SEND);

    // result item
    always_comb
    begin
        value_data.value_byte = is_empty ? 8'h00 : rd_data_reg;
        value_data.last       = is_last;
        value_data.empty_res  = is_empty;
        value_data.truncated  = ovf_reg;
    end

    // drain sequencer: read one buffer entry, then offer it; an empty value is offered without a read
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= B_IDLE;
            idx_reg   <= '0;
            cnt_reg   <= '0;
            ovf_reg   <= 1'b0;
        end
        else
        begin
            case (state_reg)
                B_IDLE:
                begin
                    if (cmd_avail)
                    begin
                        cnt_reg   <= cmd_data.cnt;
                        ovf_reg   <= cmd_data.overflow;
                        idx_reg   <= '0;
                        state_reg <= (cmd_data.cnt == '0) ? B_SEND : B_READ;
                    end
                end
                B_READ:
                begin
                    state_reg <= B_SEND;
                end
                B_SEND:
                begin
                    if (!value_stall)
                    begin
                        if (is_last)
                        begin
                            state_reg <= B_IDLE;
                        end
                        else
                        begin
                            idx_reg   <= idx_reg + qkve_pkg::ADDR_W'(1);
                            state_reg <= B_READ;
                        end
                    end
                end
                default:
                begin
                    state_reg <= B_IDLE;
                end
            endcase
        end
    end

    // value buffer
    always_ff @(posedge clk)
    begin
        if (buf_wr.en)
        begin
            value_buf[buf_wr.addr] <= buf_wr.data;
        end
        if (state_reg == B_READ)
        begin
            rd_data_reg <= value_buf[idx_reg];
        end
    end

`ifndef SYNTHESIS
    // scanner never writes the buffer while a value is pending or draining
    assert property (@(posedge clk) disable iff (!rst_n)
        buf_wr.en |-> (state_reg == B_IDLE && !cmd_avail))
        else $error("buffer written during drain");

    // after the final byte goes out there is a gap before the next value
    assert property (@(posedge clk) disable iff (!rst_n)
        (value_valid && !value_stall && value_data.last) |=> !value_valid)
        else $error("result offered right after last byte");

    // queued lengths fit the buffer
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == B_IDLE && cmd_avail) |-> (cmd_data.cnt <= qkve_pkg::VALUE_MAX))
        else $error("queued length exceeds buffer");

    // read position stays inside the value
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == B_SEND && !is_empty) |-> (qkve_pkg::CNT_W'(idx_reg) < cnt_reg))
        else $error("read position past value end");
`endif

endmodule

// ----- rtl/quoted_key_value_extractor_core.sv -----
`timescale 1ns / 1ps

// Quoted key/value extractor. Scans a byte stream for double-quoted strings and, once a
// string equal to the key (ASCII case folded, no colon since the last bracket or brace) has
// been seen, buffers the next quoted string and emits it one byte per item after its closing
// quote, with last set on the final byte, empty_res on an empty value and truncated on every
// byte of a value longer than 64 characters. The scanner takes one input item per cycle when
// not stalled. Each value byte drains through a buffer read, then the output register; the
// scanner keeps running during the drain, but once a new key has been
// found it stalls input until the previous value has been drained, so the buffer is never
// overwritten early. An end-of-message item clears the scan state. The key registers sit at
// byte addresses 0 to 28 (key length, then four key characters per word, lowest in the low
// byte).

module quoted_key_value_extractor_core
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             scan_valid,
    output logic                             scan_stall,
    input  qkve_pkg::scan_item_t             scan_data,
    output logic                             value_valid,
    input  logic                             value_stall,
    output qkve_pkg::value_item_t            value_data,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [qkve_pkg::PADDR_W-1:0]     paddr,
    input  logic [qkve_pkg::PDATA_W-1:0]     pwdata,
    output logic [qkve_pkg::PDATA_W-1:0]     prdata,
    output logic                             pready
);

    logic [qkve_pkg::KEY_LEN_W-1:0] key_length;
    logic [qkve_pkg::KEY_W-1:0]     key_chars;
    logic                           cmd_full;
    logic                           cmd_push;
    logic                           cmd_pop;
    logic                           cmd_avail;
    logic                           back_busy;
    qkve_pkg::cmd_t                 cmd_in;
    qkve_pkg::cmd_t                 cmd_out;
    qkve_pkg::buf_wr_t              buf_wr;

    // configuration registers
    qkve_regs u_regs
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready),
        .key_length (key_length),
        .key_chars  (key_chars)
    );

    // scanner
    qkve_front u_front
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .scan_valid (scan_valid),
        .scan_stall (scan_stall),
        .scan_data  (scan_data),
        .key_length (key_length),
        .key_chars  (key_chars),
        .cmd_full   (cmd_full),
        .back_busy  (back_busy),
        .cmd_push   (cmd_push),
        .cmd_data   (cmd_in),
        .buf_wr     (buf_wr)
    );

    // finished values waiting to drain
    qkve_cmd_fifo u_cmd_fifo
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (cmd_push),
        .push_data (cmd_in),
        .full      (cmd_full),
        .pop       (cmd_pop),
        .pop_data  (cmd_out),
        .avail     (cmd_avail)
    );

    // buffer and drain
    qkve_back u_back
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd_avail   (cmd_avail),
        .cmd_data    (cmd_out),
        .cmd_pop     (cmd_pop),
        .buf_wr      (buf_wr),
        .busy        (back_busy),
        .value_valid (value_valid),
        .value_stall (value_stall),
        .value_data  (value_data)
    );

endmodule
